/* hw/rtl/jpeg_marker_segment_parser_macros.svh */
`ifndef JPEG_MARKER_SEGMENT_PARSER_MACROS_SVH
`define JPEG_MARKER_SEGMENT_PARSER_MACROS_SVH

// Clocked assertion with reset disable
`define JMSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication with the consequent checked in the next cycle
`define JMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/jmsp_pkg.sv */
package jmsp_pkg;

  localparam logic [3:0] EvSegEnd    = 4'd0;
  localparam logic [3:0] EvFrame     = 4'd1;
  localparam logic [3:0] EvJfif      = 4'd2;
  localparam logic [3:0] EvComChar   = 4'd3;
  localparam logic [3:0] EvScanStart = 4'd4;
  localparam logic [3:0] EvNotJpeg   = 4'd5;
  localparam logic [3:0] EvEoi       = 4'd6;
  localparam logic [3:0] EvTruncated = 4'd7;
  localparam logic [3:0] EvBadLength = 4'd8;
  localparam logic [3:0] EvPadWarn   = 4'd9;

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkApp0   = 8'hE0;
  localparam logic [7:0] MarkCom    = 8'hFE;

  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChQmark = 8'h3F;

  localparam logic [15:0] DefDensity = 16'd300;
  localparam logic [7:0]  DefUnits   = 8'd1;
  localparam logic [15:0] MinFrameLen = 16'd8;
  localparam logic [15:0] MinJfifLen  = 16'd16;
  localparam int          MaxRes      = 3;

  function automatic logic is_frame(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
  endfunction

  function automatic logic [7:0] filt(input logic [7:0] b);
    return (b >= ChSpace || b == ChLf || b == ChTab) ? b : ChQmark;
  endfunction

endpackage

/* hw/rtl/jpeg_marker_segment_parser.sv */
// JPEG marker segment parser.
// Input channel: one file byte per beat on data_byte_i, or an end-of-stream
// beat with stream_end_i high, handshaked by in_valid_i / in_ready_o.
// Output channel: result beats (event, marker, length, frame and JFIF fields,
// comment character) handshaked by out_valid_o / out_ready_i; last_of_run_o
// marks the final result caused by one input beat.
// Latency: the results of a beat appear the cycle after it is accepted.
// Throughput: one input beat per cycle while each gives at most one result and the
// receiver is ready; a beat giving more results holds the output until the three-entry
// result buffer has drained, one entry per cycle while the receiver is ready.
// The next input is accepted in the same cycle as the last result of the
// previous one is taken, so a beat with no result never stalls.
// When the receiver stalls, the buffer holds and input is stalled until the
// last buffered result is taken.
// Reset: parser expects the SOI pair, no results pending, comment extraction on.
// cfg_we_i writes the comment extraction enable from cfg_data_i at the clock edge.
module jpeg_marker_segment_parser #(
  parameter int MAX_COMMENT_LEN = 2000,
  parameter int PAD_WARN_LIMIT  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [7:0]  marker_code_o,
  output logic [15:0] segment_length_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        is_color_o,
  output logic [7:0]  density_units_o,
  output logic [15:0] x_density_o,
  output logic [15:0] y_density_o,
  output logic [7:0]  comment_char_o,
  output logic        last_of_run_o
);

  `include "jpeg_marker_segment_parser_macros.svh"

  localparam logic [2:0] PhSoi1 = 3'd0;
  localparam logic [2:0] PhSoi2 = 3'd1;
  localparam logic [2:0] PhMark = 3'd2;
  localparam logic [2:0] PhLenH = 3'd3;
  localparam logic [2:0] PhLenL = 3'd4;
  localparam logic [2:0] PhBody = 3'd5;
  localparam logic [2:0] PhStop = 3'd6;

  localparam logic [15:0] ComLim = 16'(MAX_COMMENT_LEN);
  localparam logic [3:0]  PadLim = 4'(PAD_WARN_LIMIT);

  logic [2:0]  phase_q, phase_d;
  logic        prev_ff_q, prev_ff_d;
  logic [3:0]  pad_q, pad_d;
  logic [7:0]  marker_q, marker_d;
  logic [15:0] seg_len_q, seg_len_d;
  logic [15:0] seg_idx_q, seg_idx_d;
  logic        com_seen_q, com_seen_d;
  logic        cr_q, cr_d;
  logic        com_act_q, com_act_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        color_q, color_d;
  logic [7:0]  units_q, units_d;
  logic [15:0] xden_q, xden_d;
  logic [15:0] yden_q, yden_d;
  logic        rd_meta_q;

  logic [3:0]  ev_v [jmsp_pkg::MaxRes];
  logic [7:0]  ch_v [jmsp_pkg::MaxRes];
  logic [1:0]  n_v;
  logic        done_v;
  logic        handled_v;
  logic [15:0] lim_v;
  logic [16:0] ip1_v;
  logic [15:0] len_v;

  logic [3:0]  ev_q [jmsp_pkg::MaxRes];
  logic [7:0]  ch_q [jmsp_pkg::MaxRes];
  logic [1:0]  cnt_q;
  logic [1:0]  idx_q;
  logic [7:0]  o_marker_q;
  logic [15:0] o_len_q, o_width_q, o_height_q, o_xden_q, o_yden_q;
  logic        o_color_q;
  logic [7:0]  o_units_q;

  logic in_acc, out_acc, last_res;

  assign out_valid_o = (cnt_q != 2'd0);
  assign last_res    = (idx_q == cnt_q - 2'd1);
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (last_res && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    prev_ff_d  = prev_ff_q;
    pad_d      = pad_q;
    marker_d   = marker_q;
    seg_len_d  = seg_len_q;
    seg_idx_d  = seg_idx_q;
    com_seen_d = com_seen_q;
    cr_d       = cr_q;
    com_act_d  = com_act_q;
    width_d    = width_q;
    height_d   = height_q;
    color_d    = color_q;
    units_d    = units_q;
    xden_d     = xden_q;
    yden_d     = yden_q;
    for (int k = 0; k < jmsp_pkg::MaxRes; k++) begin
      ev_v[k] = jmsp_pkg::EvSegEnd;
      ch_v[k] = 8'd0;
    end
    n_v       = 2'd0;
    done_v    = 1'b0;
    handled_v = 1'b0;
    lim_v     = (seg_len_q < ComLim) ? seg_len_q : ComLim;
    ip1_v     = {1'b0, seg_idx_q} + 17'd1;
    len_v     = {seg_len_q[15:8], data_byte_i};

    if (stream_end_i) begin
      if (phase_q == PhSoi1 || phase_q == PhSoi2) begin
        ev_v[n_v] = jmsp_pkg::EvNotJpeg; n_v = n_v + 2'd1;
      end else if (phase_q != PhStop) begin
        ev_v[n_v] = jmsp_pkg::EvTruncated; n_v = n_v + 2'd1;
      end
      phase_d    = PhSoi1;
      prev_ff_d  = 1'b0;
      pad_d      = 4'd0;
      marker_d   = 8'd0;
      seg_len_d  = 16'd0;
      seg_idx_d  = 16'd0;
      com_seen_d = 1'b0;
      cr_d       = 1'b0;
      com_act_d  = 1'b0;
      width_d    = 16'd0;
      height_d   = 16'd0;
      color_d    = 1'b0;
      units_d    = jmsp_pkg::DefUnits;
      xden_d     = jmsp_pkg::DefDensity;
      yden_d     = jmsp_pkg::DefDensity;
    end else begin
      case (phase_q)
        PhSoi1: begin
          if (data_byte_i == jmsp_pkg::MarkPrefix) begin
            phase_d = PhSoi2;
          end else begin
            ev_v[n_v] = jmsp_pkg::EvNotJpeg; n_v = n_v + 2'd1;
            phase_d = PhStop;
          end
        end
        PhSoi2: begin
          if (data_byte_i == jmsp_pkg::MarkSoi) begin
            units_d   = jmsp_pkg::DefUnits;
            xden_d    = jmsp_pkg::DefDensity;
            yden_d    = jmsp_pkg::DefDensity;
            prev_ff_d = 1'b0;
            pad_d     = 4'd0;
            phase_d   = PhMark;
          end else begin
            ev_v[n_v] = jmsp_pkg::EvNotJpeg; n_v = n_v + 2'd1;
            phase_d = PhStop;
          end
        end
        PhMark: begin
          if (data_byte_i != jmsp_pkg::MarkPrefix && prev_ff_q) begin
            marker_d  = data_byte_i;
            seg_len_d = 16'd0;
            seg_idx_d = 16'd0;
            if (pad_q > PadLim) begin
              ev_v[n_v] = jmsp_pkg::EvPadWarn; n_v = n_v + 2'd1;
            end
            pad_d     = 4'd0;
            prev_ff_d = 1'b0;
            if (data_byte_i == jmsp_pkg::MarkEoi) begin
              ev_v[n_v] = jmsp_pkg::EvEoi; n_v = n_v + 2'd1;
              phase_d = PhStop;
            end else begin
              phase_d = PhLenH;
            end
          end else begin
            if (pad_q != 4'hF) pad_d = pad_q + 4'd1;
            prev_ff_d = (data_byte_i == jmsp_pkg::MarkPrefix);
          end
        end
        PhLenH: begin
          seg_len_d = {data_byte_i, 8'd0};
          phase_d   = PhLenL;
        end
        PhLenL: begin
          seg_len_d = len_v;
          if (len_v < 16'd2) begin
            ev_v[n_v] = jmsp_pkg::EvBadLength; n_v = n_v + 2'd1;
            phase_d = PhStop;
          end else begin
            seg_idx_d = 16'd2;
            cr_d      = 1'b0;
            com_act_d = 1'b0;
            if (marker_q == jmsp_pkg::MarkCom && rd_meta_q && !com_seen_q) begin
              com_act_d  = 1'b1;
              com_seen_d = 1'b1;
            end
            phase_d = PhBody;
            if (len_v == 16'd2) done_v = 1'b1;
          end
        end
        PhBody: begin
          if (jmsp_pkg::is_frame(marker_q) && seg_len_q >= jmsp_pkg::MinFrameLen) begin
            case (seg_idx_q)
              16'd3:   height_d = {data_byte_i, height_q[7:0]};
              16'd4:   height_d = {height_q[15:8], data_byte_i};
              16'd5:   width_d  = {data_byte_i, width_q[7:0]};
              16'd6:   width_d  = {width_q[15:8], data_byte_i};
              16'd7:   color_d  = (data_byte_i == 8'd3);
              default: ;
            endcase
          end
          if (marker_q == jmsp_pkg::MarkApp0 && seg_len_q >= jmsp_pkg::MinJfifLen) begin
            case (seg_idx_q)
              16'd9:   units_d = data_byte_i;
              16'd10:  xden_d  = {data_byte_i, xden_q[7:0]};
              16'd11:  xden_d  = {xden_q[15:8], data_byte_i};
              16'd12:  yden_d  = {data_byte_i, yden_q[7:0]};
              16'd13:  yden_d  = {yden_q[15:8], data_byte_i};
              default: ;
            endcase
          end
          if (com_act_q && seg_idx_q < lim_v) begin
            if (cr_q) begin
              cr_d = 1'b0;
              if (data_byte_i == jmsp_pkg::ChLf) begin
                ev_v[n_v] = jmsp_pkg::EvComChar; ch_v[n_v] = jmsp_pkg::ChLf;
                n_v = n_v + 2'd1;
                handled_v = 1'b1;
              end else begin
                ev_v[n_v] = jmsp_pkg::EvComChar; ch_v[n_v] = jmsp_pkg::ChQmark;
                n_v = n_v + 2'd1;
              end
            end
            if (!handled_v) begin
              if (data_byte_i == jmsp_pkg::ChCr) begin
                if (ip1_v >= {1'b0, lim_v}) begin
                  ev_v[n_v] = jmsp_pkg::EvComChar; ch_v[n_v] = jmsp_pkg::ChQmark;
                  n_v = n_v + 2'd1;
                end else begin
                  cr_d = 1'b1;
                end
              end else begin
                ev_v[n_v] = jmsp_pkg::EvComChar; ch_v[n_v] = jmsp_pkg::filt(data_byte_i);
                n_v = n_v + 2'd1;
              end
            end
          end
          seg_idx_d = ip1_v[15:0];
          if (ip1_v >= {1'b0, seg_len_q}) done_v = 1'b1;
        end
        default: ;
      endcase

      if (done_v) begin
        if (marker_d == jmsp_pkg::MarkSos) begin
          ev_v[n_v] = jmsp_pkg::EvScanStart; n_v = n_v + 2'd1;
          phase_d = PhStop;
        end else begin
          if (jmsp_pkg::is_frame(marker_d) && seg_len_d >= jmsp_pkg::MinFrameLen) begin
            ev_v[n_v] = jmsp_pkg::EvFrame; n_v = n_v + 2'd1;
          end
          if (marker_d == jmsp_pkg::MarkApp0 && seg_len_d >= jmsp_pkg::MinJfifLen) begin
            ev_v[n_v] = jmsp_pkg::EvJfif; n_v = n_v + 2'd1;
          end
          ev_v[n_v] = jmsp_pkg::EvSegEnd; n_v = n_v + 2'd1;
          phase_d   = PhMark;
          prev_ff_d = 1'b0;
          pad_d     = 4'd0;
          com_act_d = 1'b0;
          cr_d      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSoi1;
      prev_ff_q  <= 1'b0;
      pad_q      <= 4'd0;
      marker_q   <= 8'd0;
      seg_len_q  <= 16'd0;
      seg_idx_q  <= 16'd0;
      com_seen_q <= 1'b0;
      cr_q       <= 1'b0;
      com_act_q  <= 1'b0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      color_q    <= 1'b0;
      units_q    <= jmsp_pkg::DefUnits;
      xden_q     <= jmsp_pkg::DefDensity;
      yden_q     <= jmsp_pkg::DefDensity;
      rd_meta_q  <= 1'b1;
      cnt_q      <= 2'd0;
      idx_q      <= 2'd0;
    end else begin
      if (cfg_we_i) rd_meta_q <= cfg_data_i;
      if (in_acc) begin
        phase_q    <= phase_d;
        prev_ff_q  <= prev_ff_d;
        pad_q      <= pad_d;
        marker_q   <= marker_d;
        seg_len_q  <= seg_len_d;
        seg_idx_q  <= seg_idx_d;
        com_seen_q <= com_seen_d;
        cr_q       <= cr_d;
        com_act_q  <= com_act_d;
        width_q    <= width_d;
        height_q   <= height_d;
        color_q    <= color_d;
        units_q    <= units_d;
        xden_q     <= xden_d;
        yden_q     <= yden_d;
        cnt_q      <= n_v;
        idx_q      <= 2'd0;
      end else if (out_acc) begin
        if (last_res) begin
          cnt_q <= 2'd0;
          idx_q <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // hold the result snapshot; on end of stream the fields are taken before rearm
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q <= ev_v;
      ch_q <= ch_v;
      if (stream_end_i) begin
        o_marker_q <= marker_q;
        o_len_q    <= seg_len_q;
        o_width_q  <= width_q;
        o_height_q <= height_q;
        o_color_q  <= color_q;
        o_units_q  <= units_q;
        o_xden_q   <= xden_q;
        o_yden_q   <= yden_q;
      end else begin
        o_marker_q <= marker_d;
        o_len_q    <= seg_len_d;
        o_width_q  <= width_d;
        o_height_q <= height_d;
        o_color_q  <= color_d;
        o_units_q  <= units_d;
        o_xden_q   <= xden_d;
        o_yden_q   <= yden_d;
      end
    end
  end

  assign event_res_o      = ev_q[idx_q];
  assign comment_char_o   = ch_q[idx_q];
  assign last_of_run_o    = last_res;
  assign marker_code_o    = o_marker_q;
  assign segment_length_o = o_len_q;
  assign image_width_o    = o_width_q;
  assign image_height_o   = o_height_q;
  assign is_color_o       = o_color_q;
  assign density_units_o  = o_units_q;
  assign x_density_o      = o_xden_q;
  assign y_density_o      = o_yden_q;

  `JMSP_ASSERT(a_idx_in_range, (cnt_q == 2'd0) || (idx_q < cnt_q), "result index past count")
  `JMSP_ASSERT_NEXT(a_stop_silent,
    in_acc && !stream_end_i && (phase_q == PhStop), cnt_q == 2'd0,
    "stopped parser produced a result")
  `JMSP_ASSERT_NEXT(a_end_rearms, in_acc && stream_end_i,
    (phase_q == PhSoi1) && (cnt_q <= 2'd1), "end of stream did not rearm")
  `JMSP_ASSERT(a_cr_only_in_comment, !cr_q || com_act_q, "CR pending outside comment")

endmodule

/* tb/jmsp_result_checker.sv */
`timescale 1ns / 100ps

module jmsp_result_checker #(
  parameter int MaxComLen    = 2000,
  parameter int PadWarnLimit = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  event_res_i,
  input  logic [7:0]  marker_code_i,
  input  logic [15:0] segment_length_i,
  input  logic [15:0] image_width_i,
  input  logic [15:0] image_height_i,
  input  logic        is_color_i,
  input  logic [7:0]  density_units_i,
  input  logic [15:0] x_density_i,
  input  logic [15:0] y_density_i,
  input  logic [7:0]  comment_char_i,
  input  logic        last_of_run_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          checked_o
);

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  marker;
    logic [15:0] seg_len;
    logic [15:0] width;
    logic [15:0] height;
    logic        colour;
    logic [7:0]  units;
    logic [15:0] xden;
    logic [15:0] yden;
    logic [7:0]  ch;
    logic        last;
  } parse_res_t;

  typedef enum logic [2:0] {
    PhSoi1, PhSoi2, PhMark, PhLenH, PhLenL, PhBody, PhStop
  } parse_phase_e;

  parse_phase_e phase = PhSoi1;
  logic        ff_seen = 1'b0;
  logic [3:0]  pads = 4'd0;
  logic [7:0]  marker = 8'd0;
  logic [15:0] seg_len = 16'd0;
  logic [15:0] seg_idx = 16'd0;
  logic        com_seen = 1'b0;
  logic        cr_hold = 1'b0;
  logic        com_on = 1'b0;
  logic [15:0] width = 16'd0;
  logic [15:0] height = 16'd0;
  logic        colour = 1'b0;
  logic [7:0]  units = jmsp_pkg::DefUnits;
  logic [15:0] xden = jmsp_pkg::DefDensity;
  logic [15:0] yden = jmsp_pkg::DefDensity;
  logic        meta_en = 1'b1;

  parse_res_t expect_q[$];
  parse_res_t step_q[$];
  int fails = 0;
  int checked = 0;

  initial pending_o = 0;
  assign fail_count_o = fails;
  assign checked_o    = checked;

  task automatic push_res(input logic [3:0] ev, input logic [7:0] ch);
    if (step_q.size() < 4)
      step_q.push_back(parse_res_t'{ev, marker, seg_len, width, height, colour, units,
                                    xden, yden, ch, 1'b0});
  endtask

  task automatic rearm_parser();
    phase = PhSoi1; ff_seen = 1'b0; pads = 4'd0; marker = 8'd0; seg_len = 16'd0;
    seg_idx = 16'd0; com_seen = 1'b0; cr_hold = 1'b0; com_on = 1'b0; width = 16'd0;
    height = 16'd0; colour = 1'b0;
    units = jmsp_pkg::DefUnits; xden = jmsp_pkg::DefDensity; yden = jmsp_pkg::DefDensity;
  endtask

  function automatic logic frame_marker(input logic [7:0] m);
    return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
  endfunction

  task automatic close_segment();
    if (marker == jmsp_pkg::MarkSos) begin
      push_res(jmsp_pkg::EvScanStart, 8'd0);
      phase = PhStop;
    end else begin
      if (frame_marker(marker) && seg_len >= jmsp_pkg::MinFrameLen)
        push_res(jmsp_pkg::EvFrame, 8'd0);
      if (marker == jmsp_pkg::MarkApp0 && seg_len >= jmsp_pkg::MinJfifLen)
        push_res(jmsp_pkg::EvJfif, 8'd0);
      push_res(jmsp_pkg::EvSegEnd, 8'd0);
      phase = PhMark; ff_seen = 1'b0; pads = 4'd0; com_on = 1'b0; cr_hold = 1'b0;
    end
  endtask

  task automatic body_byte(input logic [7:0] b);
    int i;
    int lim;
    logic handled;
    i = seg_idx;
    if (frame_marker(marker) && seg_len >= jmsp_pkg::MinFrameLen) begin
      case (i)
        3: height[15:8] = b;
        4: height[7:0] = b;
        5: width[15:8] = b;
        6: width[7:0] = b;
        7: colour = (b == 8'd3);
        default: ;
      endcase
    end
    if (marker == jmsp_pkg::MarkApp0 && seg_len >= jmsp_pkg::MinJfifLen) begin
      case (i)
        9: units = b;
        10: xden[15:8] = b;
        11: xden[7:0] = b;
        12: yden[15:8] = b;
        13: yden[7:0] = b;
        default: ;
      endcase
    end
    if (com_on) begin
      lim = (seg_len < MaxComLen) ? int'(seg_len) : MaxComLen;
      if (i < lim) begin
        handled = 1'b0;
        if (cr_hold) begin
          cr_hold = 1'b0;
          if (b == jmsp_pkg::ChLf) begin
            push_res(jmsp_pkg::EvComChar, jmsp_pkg::ChLf);
            handled = 1'b1;
          end else begin
            push_res(jmsp_pkg::EvComChar, jmsp_pkg::ChQmark);
          end
        end
        if (!handled) begin
          if (b == jmsp_pkg::ChCr) begin
            if (i + 1 >= lim) push_res(jmsp_pkg::EvComChar, jmsp_pkg::ChQmark);
            else cr_hold = 1'b1;
          end else begin
            push_res(jmsp_pkg::EvComChar,
                     (b >= jmsp_pkg::ChSpace || b == jmsp_pkg::ChLf || b == jmsp_pkg::ChTab)
                     ? b : jmsp_pkg::ChQmark);
          end
        end
      end
    end
    seg_idx = 16'(i + 1);
    if (i + 1 >= int'(seg_len)) close_segment();
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic eos);
    step_q.delete();
    if (eos) begin
      if (phase == PhSoi1 || phase == PhSoi2) push_res(jmsp_pkg::EvNotJpeg, 8'd0);
      else if (phase != PhStop) push_res(jmsp_pkg::EvTruncated, 8'd0);
      rearm_parser();
    end else begin
      case (phase)
        PhSoi1: begin
          if (b == jmsp_pkg::MarkPrefix) phase = PhSoi2;
          else begin
            push_res(jmsp_pkg::EvNotJpeg, 8'd0);
            phase = PhStop;
          end
        end
        PhSoi2: begin
          if (b == jmsp_pkg::MarkSoi) begin
            units = jmsp_pkg::DefUnits; xden = jmsp_pkg::DefDensity;
            yden = jmsp_pkg::DefDensity;
            ff_seen = 1'b0; pads = 4'd0; phase = PhMark;
          end else begin
            push_res(jmsp_pkg::EvNotJpeg, 8'd0);
            phase = PhStop;
          end
        end
        PhMark: begin
          if (b != jmsp_pkg::MarkPrefix && ff_seen) begin
            marker = b; seg_len = 16'd0; seg_idx = 16'd0;
            if (pads > PadWarnLimit) push_res(jmsp_pkg::EvPadWarn, 8'd0);
            pads = 4'd0; ff_seen = 1'b0;
            if (b == jmsp_pkg::MarkEoi) begin
              push_res(jmsp_pkg::EvEoi, 8'd0);
              phase = PhStop;
            end else begin
              phase = PhLenH;
            end
          end else begin
            if (pads < 4'd15) pads = pads + 4'd1;
            ff_seen = (b == jmsp_pkg::MarkPrefix);
          end
        end
        PhLenH: begin
          seg_len = {b, 8'd0};
          phase = PhLenL;
        end
        PhLenL: begin
          seg_len[7:0] = b;
          if (seg_len < 16'd2) begin
            push_res(jmsp_pkg::EvBadLength, 8'd0);
            phase = PhStop;
          end else begin
            seg_idx = 16'd2; cr_hold = 1'b0; com_on = 1'b0;
            if (marker == jmsp_pkg::MarkCom && meta_en && !com_seen) begin
              com_on = 1'b1;
              com_seen = 1'b1;
            end
            phase = PhBody;
            if (seg_len == 16'd2) close_segment();
          end
        end
        PhBody: body_byte(b);
        default: ;
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[k]) expect_q.push_back(step_q[k]);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    parse_res_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result beat, event %0d", $time, event_res_i);
          fails++;
        end else begin
          e = expect_q.pop_front();
          checked++;
          check_field("event_res", e.ev, event_res_i);
          check_field("marker_code", e.marker, marker_code_i);
          check_field("segment_length", e.seg_len, segment_length_i);
          check_field("image_width", e.width, image_width_i);
          check_field("image_height", e.height, image_height_i);
          check_field("is_color", e.colour, is_color_i);
          check_field("density_units", e.units, density_units_i);
          check_field("x_density", e.xden, x_density_i);
          check_field("y_density", e.yden, y_density_i);
          check_field("comment_char", e.ch, comment_char_i);
          check_field("last_of_run", e.last, last_of_run_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_beat(data_byte_i, stream_end_i);
      if (cfg_we_i) meta_en = cfg_data_i;
    end
    pending_o = expect_q.size();
  end

endmodule

/* tb/tb_jpeg_marker_segment_parser.sv */
`timescale 1ns / 100ps

module tb_jpeg_marker_segment_parser;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } beat_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 0;
  logic        stream_end_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [3:0]  event_res_o;
  logic [7:0]  marker_code_o;
  logic [15:0] segment_length_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        is_color_o;
  logic [7:0]  density_units_o;
  logic [15:0] x_density_o;
  logic [15:0] y_density_o;
  logic [7:0]  comment_char_o;
  logic        last_of_run_o;

  int pending;
  int fail_count;
  int checked;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  logic hold_go = 0;
  int quiet = 0;
  int streams = 0;
  beat_t beat_q[$];

  always #6 clk_i = ~clk_i;

  jpeg_marker_segment_parser u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .data_byte_i, .stream_end_i, .out_valid_o, .out_ready_i, .event_res_o,
    .marker_code_o, .segment_length_o, .image_width_o, .image_height_o,
    .is_color_o, .density_units_o, .x_density_o, .y_density_o,
    .comment_char_o, .last_of_run_o
  );

  jmsp_result_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o),
    .data_byte_i, .stream_end_i, .out_valid_i(out_valid_o), .out_ready_i,
    .event_res_i(event_res_o), .marker_code_i(marker_code_o),
    .segment_length_i(segment_length_o), .image_width_i(image_width_o),
    .image_height_i(image_height_o), .is_color_i(is_color_o),
    .density_units_i(density_units_o), .x_density_i(x_density_o),
    .y_density_i(y_density_o), .comment_char_i(comment_char_o),
    .last_of_run_i(last_of_run_o), .pending_o(pending), .fail_count_o(fail_count),
    .checked_o(checked)
  );

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
        $display("jpeg_marker_segment_parser test failed");
        $finish;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    beat_q.push_back('{b, 1'b0});
  endtask

  task automatic add_end();
    beat_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
    streams++;
  endtask

  task automatic add_marker(input logic [7:0] m);
    int k;
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    for (int j = 0; j < k; j++)
      add_byte((j == 0 && $urandom_range(0, 1)) ? 8'($urandom_range(0, 254))
                                                : jmsp_pkg::MarkPrefix);
    add_byte(jmsp_pkg::MarkPrefix);
    add_byte(m);
  endtask

  function automatic logic [7:0] comment_byte();
    case ($urandom_range(0, 5))
      0: return jmsp_pkg::ChCr;
      1: return jmsp_pkg::ChLf;
      2: return jmsp_pkg::ChTab;
      3: return 8'($urandom_range(0, 31));
      4: return 8'($urandom_range(32, 126));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_segment(input logic [7:0] m, input int len);
    add_marker(m);
    add_byte(8'(len >> 8));
    add_byte(8'(len));
    for (int j = 2; j < len; j++)
      add_byte(m == jmsp_pkg::MarkCom ? comment_byte() : 8'($urandom_range(0, 255)));
  endtask

  task automatic add_stream();
    int nseg;
    logic [7:0] m;
    if ($urandom_range(0, 99) < 6) begin
      case ($urandom_range(0, 3))
        0: add_byte(8'($urandom_range(0, 254)));
        1: begin
          add_byte(jmsp_pkg::MarkPrefix);
          add_byte($urandom_range(0, 1) ? jmsp_pkg::MarkPrefix : 8'($urandom_range(0, 215)));
        end
        2: add_byte(jmsp_pkg::MarkPrefix);
        default: ;
      endcase
      add_end();
      return;
    end
    add_byte(jmsp_pkg::MarkPrefix);
    add_byte(jmsp_pkg::MarkSoi);
    nseg = $urandom_range(0, 4);
    for (int s = 0; s < nseg; s++) begin
      case ($urandom_range(0, 3))
        0: begin
          m = 8'hC0 + 8'($urandom_range(0, 15));
          if (m == 8'hC4 || m == 8'hC8 || m == 8'hCC) m = m + 8'd1;
          add_segment(m, $urandom_range(0, 4) == 0 ? $urandom_range(2, 7)
                                                   : $urandom_range(8, 14));
        end
        1: add_segment(jmsp_pkg::MarkApp0, $urandom_range(0, 4) == 0 ? $urandom_range(2, 15)
                                                                     : $urandom_range(16, 20));
        2: add_segment(jmsp_pkg::MarkCom, $urandom_range(2, 24));
        default: begin
          m = 8'($urandom_range(0, 254));
          if (m == jmsp_pkg::MarkEoi || m == jmsp_pkg::MarkSos) m = 8'hC4;
          add_segment(m, $urandom_range(2, 12));
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        add_segment(jmsp_pkg::MarkSos, $urandom_range(2, 10));
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        add_marker(jmsp_pkg::MarkEoi);
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        add_marker(8'($urandom_range(0, 1) ? jmsp_pkg::MarkCom : 8'hC1));
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
      end
      4: begin
        add_marker(8'($urandom_range(0, 1) ? jmsp_pkg::MarkApp0 : 8'h42));
        add_byte(8'd0);
        add_byte(8'($urandom_range(0, 1)));
      end
      default: if ($urandom_range(0, 1)) add_byte(jmsp_pkg::MarkPrefix);
    endcase
    add_end();
  endtask

  task automatic send_all();
    beat_t x;
    while (beat_q.size() > 0) begin
      x = beat_q.pop_front();
      while ($urandom_range(0, 99) < send_idle) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i   <= 1'b1;
      data_byte_i  <= x.b;
      stream_end_i <= x.eos;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_meta(input logic v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic meta,
                           input int n_items);
    send_idle = idle;
    recv_stall = stall;
    write_meta(meta);
    add_stream();
    while (beat_q.size() < n_items) add_stream();
    send_all();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // comment with CR/LF handling, CR on the last byte, then a frame and EOI
    write_meta(1'b1);
    add_byte(jmsp_pkg::MarkPrefix); add_byte(jmsp_pkg::MarkSoi);
    add_byte(jmsp_pkg::MarkPrefix); add_byte(jmsp_pkg::MarkCom);
    add_byte(8'h00); add_byte(8'h08);
    add_byte(8'h41); add_byte(jmsp_pkg::ChCr); add_byte(jmsp_pkg::ChLf);
    add_byte(jmsp_pkg::ChCr); add_byte(8'h78);
    add_byte(jmsp_pkg::ChCr);
    add_byte(jmsp_pkg::MarkPrefix); add_byte(8'hC0); add_byte(8'h00); add_byte(8'h08);
    add_byte(8'h08); add_byte(8'hFF); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00);
    add_byte(8'h03);
    add_byte(jmsp_pkg::MarkPrefix); add_byte(jmsp_pkg::MarkEoi);
    add_end();
    send_all();
    drain();

    run_phase(0, 0, 1'b0, 40);
    run_phase(67, 0, 1'b1, 40);
    hold_go = 1;
    run_phase(0, 67, 1'b0, 40);
    run_phase(31, 31, 1'b1, 40);
    run_phase(0, 0, 1'b1, 40);

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Parsed %0d byte streams (valid, malformed, truncated) and checked %0d results",
             streams, checked);
    $display("with comment extraction on and off under sender and receiver stalls.");
    if (fail_count == 0) begin
      $display("jpeg_marker_segment_parser test passed");
    end else begin
      $display("jpeg_marker_segment_parser test failed");
    end
    $finish;
  end

endmodule
